// File: rtl/set_assoc_cache_lru_writeback_top_assert.svh
// Assertion macros used by the cache tag store back end
`ifndef SET_ASSOC_CACHE_LRU_WRITEBACK_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_WRITEBACK_TOP_ASSERT_SVH

// a property that must hold at every clock edge outside reset
`define SACL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// an implication whose consequent is checked at the next clock edge
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Commands, victim codes and the front-to-back request record.
// ----------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;
   localparam int CMD_BITS  = 2;
   localparam int SET_BITS  = 6;
   localparam int TAG_BITS  = 20;
   localparam int KIND_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FILL  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NOP   = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_CLEAN = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DIRTY = 2'd2;

   typedef enum logic [1:0] {OP_LOOKUP_RD, OP_LOOKUP_WR, OP_FILL, OP_NONE} op_type;

   typedef struct packed {
      op_type              op;
      logic [SET_BITS-1:0] set_index;
      logic [TAG_BITS-1:0] tag;
      logic                fill_dirty;
   } job_type;
endpackage
`default_nettype wire

// File: rtl/sacl_front.sv
// ----------------------------------------------------------------------------
// sacl_front
// Accepts requests, classifies the command and queues them (two entries).
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sacl_pkg::CMD_BITS-1:0] req_cmd,
   input  wire logic [sacl_pkg::SET_BITS-1:0] req_set_index,
   input  wire logic [sacl_pkg::TAG_BITS-1:0] req_tag,
   input  wire logic                          req_fill_dirty,
   output logic                               job_valid,
   output sacl_pkg::job_type                  job,
   input  wire logic                          job_take
);
   sacl_pkg::job_type q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   sacl_pkg::job_type cls;
   logic              push, pop;

   always_comb begin
      case (req_cmd)
         sacl_pkg::CMD_READ:  cls.op = sacl_pkg::OP_LOOKUP_RD;
         sacl_pkg::CMD_WRITE: cls.op = sacl_pkg::OP_LOOKUP_WR;
         sacl_pkg::CMD_FILL:  cls.op = sacl_pkg::OP_FILL;
         default:             cls.op = sacl_pkg::OP_NONE;
      endcase
      cls.set_index  = req_set_index;
      cls.tag        = req_tag;
      cls.fill_dirty = req_fill_dirty;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job       = q_ff[rd_ptr_ff];
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule
`default_nettype wire

// File: rtl/sacl_back.sv
// ----------------------------------------------------------------------------
// sacl_back
// Two-step access per request: read the set, then compare, update, respond.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_lru_writeback_top_assert.svh"
module sacl_back #(
   parameter int SETS     = 64,
   parameter int WAYS     = 4,
   parameter int TAG_BITS = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           job_valid,
   input  wire sacl_pkg::job_type              job,
   output logic                                job_take,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_hit,
   output logic [sacl_pkg::KIND_BITS-1:0]      rsp_victim_kind,
   output logic [sacl_pkg::TAG_BITS-1:0]       rsp_evicted_tag
);
   localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TW = (TAG_BITS < sacl_pkg::TAG_BITS) ? TAG_BITS : sacl_pkg::TAG_BITS;
   localparam int ROW_BITS = WAYS * (TAG_BITS + 2);
   localparam int ORD_BITS = WAYS * WB;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   state_type          state_ff;
   logic [SB-1:0]      clr_ff;
   logic [SB-1:0]      set_ff;
   sacl_pkg::job_type  cur_ff;
   logic               rsp_valid_ff, rsp_hit_ff;
   logic [1:0]         rsp_kind_ff;
   logic [sacl_pkg::TAG_BITS-1:0] rsp_etag_ff;

   logic [ROW_BITS-1:0] row_rd, row_wd;
   logic [ORD_BITS-1:0] ord_rd, ord_wd, ord_init;
   logic                we;
   logic [SB-1:0]       waddr, raddr, set_sel;

   logic [TAG_BITS-1:0] tags  [WAYS];
   logic                vld   [WAYS];
   logic                drt   [WAYS];
   logic [WB-1:0]       ord   [WAYS];
   logic [WB-1:0]       nord  [WAYS];
   logic [TAG_BITS-1:0] ntags [WAYS];
   logic                nvld  [WAYS];
   logic                ndrt  [WAYS];
   logic [TAG_BITS-1:0] ctag;
   logic                found, upd;
   logic [WB-1:0]       pos, way;
   logic [1:0]          kind;
   logic [sacl_pkg::TAG_BITS-1:0] etag;

   // set index folded onto SETS through a constant table
   always_comb begin
      set_sel = '0;
      for (int v = 0; v < (1 << sacl_pkg::SET_BITS); v++)
         if (job.set_index == sacl_pkg::SET_BITS'(v)) set_sel = SB'(v % SETS);
   end

   assign raddr    = set_sel;
   assign waddr    = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign job_take = (state_ff == ST_IDLE) && job_valid && !(rsp_valid_ff && rsp_stall);

   sacl_ram #(.WIDTH(ROW_BITS), .DEPTH(SETS)) u_row (
      .clock(clock), .we(we), .waddr(waddr), .wdata(row_wd), .raddr(raddr), .rdata(row_rd));
   sacl_ram #(.WIDTH(ORD_BITS), .DEPTH(SETS)) u_ord (
      .clock(clock), .we(we), .waddr(waddr), .wdata(ord_wd), .raddr(raddr), .rdata(ord_rd));

   always_comb begin
      for (int i = 0; i < WAYS; i++) ord_init[i*WB +: WB] = WB'(i);
      ctag = TAG_BITS'(cur_ff.tag[TW-1:0]);
      for (int w = 0; w < WAYS; w++) begin
         tags[w] = row_rd[w*(TAG_BITS+2) +: TAG_BITS];
         vld[w]  = row_rd[w*(TAG_BITS+2) + TAG_BITS];
         drt[w]  = row_rd[w*(TAG_BITS+2) + TAG_BITS + 1];
         ord[w]  = ord_rd[w*WB +: WB];
      end
      found = 1'b0;
      pos   = '0;
      kind  = sacl_pkg::KIND_EMPTY;
      etag  = '0;
      upd   = 1'b0;
      if (cur_ff.op == sacl_pkg::OP_FILL) begin
         pos = WB'(WAYS - 1);
         for (int p = WAYS - 1; p >= 0; p--)
            if (!vld[ord[p]]) pos = WB'(p);
         upd = 1'b1;
      end else if (cur_ff.op == sacl_pkg::OP_LOOKUP_RD || cur_ff.op == sacl_pkg::OP_LOOKUP_WR) begin
         for (int p = WAYS - 1; p >= 0; p--)
            if (vld[ord[p]] && tags[ord[p]] == ctag) begin
               found = 1'b1;
               pos   = WB'(p);
            end
         upd = found;
      end
      way = ord[pos];
      if (cur_ff.op == sacl_pkg::OP_FILL && vld[way]) begin
         kind = drt[way] ? sacl_pkg::KIND_DIRTY : sacl_pkg::KIND_CLEAN;
         if (drt[way]) etag = sacl_pkg::TAG_BITS'(tags[way]);
      end
      for (int w = 0; w < WAYS; w++) begin
         ntags[w] = tags[w];
         nvld[w]  = vld[w];
         ndrt[w]  = drt[w];
      end
      if (cur_ff.op == sacl_pkg::OP_FILL) begin
         ntags[way] = ctag;
         nvld[way]  = 1'b1;
         ndrt[way]  = cur_ff.fill_dirty;
      end else if (cur_ff.op == sacl_pkg::OP_LOOKUP_WR && found) begin
         ndrt[way] = 1'b1;
      end
      for (int p = 0; p < WAYS; p++) begin
         if (p == 0)           nord[p] = way;
         else if (WB'(p) <= pos) nord[p] = ord[p-1];
         else                  nord[p] = ord[p];
      end
      for (int w = 0; w < WAYS; w++)
         row_wd[w*(TAG_BITS+2) +: TAG_BITS+2] = {ndrt[w], nvld[w], ntags[w]};
      for (int p = 0; p < WAYS; p++) ord_wd[p*WB +: WB] = nord[p];
      if (state_ff == ST_CLEAR) begin
         row_wd = '0;
         ord_wd = ord_init;
      end
      we = (state_ff == ST_CLEAR) || (state_ff == ST_EXEC && upd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SB'(SETS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
               if (job_take) begin
                  cur_ff   <= job;
                  set_ff   <= set_sel;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff <= 1'b1;
               rsp_hit_ff   <= found;
               rsp_kind_ff  <= kind;
               rsp_etag_ff  <= etag;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_victim_kind = rsp_kind_ff;
   assign rsp_evicted_tag = rsp_etag_ff;

   `SACL_ASSERT_NEXT(a_exec_responds, clock, reset, state_ff == ST_EXEC, rsp_valid_ff,
      "execute step gave no response")
   `SACL_ASSERT(a_no_take_when_full, clock, reset, !(job_take && rsp_valid_ff && rsp_stall),
      "request taken while response blocked")
   `SACL_ASSERT(a_fill_no_hit, clock, reset,
      !(state_ff == ST_EXEC && cur_ff.op == sacl_pkg::OP_FILL && found),
      "fill reported a hit")
endmodule
`default_nettype wire

// File: rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                                rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/set_assoc_cache_lru_writeback_top.sv
// Tag store of a set-associative write-back cache with true LRU per set. Each
// request passes through the back end in order: reading the set's row (tags,
// valid, dirty) and recency list from RAM, then comparing, choosing the way,
// writing the row back and registering the response. A two-entry queue in front
// absorbs short bursts and response stalls; req_stall rises only while both
// entries are occupied, so a sender offering a request every cycle sees
// stalls, as the back end takes a new request only once it is through with
// the last one. After reset a clearing pass over all SETS sets initialises
// the RAMs; requests are queued but not served until it ends.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_writeback_top
// Front queue plus back-end tag/LRU engine.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_lru_writeback_top #(
   parameter int SETS     = 64,
   parameter int WAYS     = 4,
   parameter int TAG_BITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sacl_pkg::CMD_BITS-1:0] req_cmd,
   input  wire logic [sacl_pkg::SET_BITS-1:0] req_set_index,
   input  wire logic [sacl_pkg::TAG_BITS-1:0] req_tag,
   input  wire logic                          req_fill_dirty,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit,
   output logic [sacl_pkg::KIND_BITS-1:0]     rsp_victim_kind,
   output logic [sacl_pkg::TAG_BITS-1:0]      rsp_evicted_tag
);
   sacl_pkg::job_type job;
   logic              job_valid, job_take;

   // front: classify and queue each request
   sacl_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_set_index(req_set_index), .req_tag(req_tag), .req_fill_dirty(req_fill_dirty),
      .job_valid(job_valid), .job(job), .job_take(job_take));

   // back: read set, update, respond
   sacl_back #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_take(job_take),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_victim_kind(rsp_victim_kind), .rsp_evicted_tag(rsp_evicted_tag));
endmodule
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the cache tag store: LRU victim choice, dirty tracking and eviction
// reports. A directed table, then random traffic on a few hot sets, each
// response compared with a behavioural model of the tag store.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSETS = 64;
   localparam int NWAYS = 4;
   localparam int N_RANDOM = 1030;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sacl_pkg::CMD_BITS-1:0] req_cmd = sacl_pkg::CMD_READ;
   logic [sacl_pkg::SET_BITS-1:0] req_set_index = '0;
   logic [sacl_pkg::TAG_BITS-1:0] req_tag = '0;
   logic req_fill_dirty = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [sacl_pkg::KIND_BITS-1:0] rsp_victim_kind;
   logic [sacl_pkg::TAG_BITS-1:0] rsp_evicted_tag;

   set_assoc_cache_lru_writeback_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // expected response record
   typedef struct packed {
      logic                           hit;
      logic [sacl_pkg::KIND_BITS-1:0] kind;
      logic [sacl_pkg::TAG_BITS-1:0]  etag;
   } outcome_type;

   // one stimulus row; chk marks a hand-written expectation
   typedef struct packed {
      logic [sacl_pkg::CMD_BITS-1:0] cmd;
      logic [sacl_pkg::SET_BITS-1:0] set_index;
      logic [sacl_pkg::TAG_BITS-1:0] tag;
      logic                          fdirty;
      logic                          chk;
      outcome_type                   want;
   } row_type;

   // model state of the tag store
   logic [sacl_pkg::TAG_BITS-1:0] mdl_tag   [NSETS][NWAYS];
   logic                          mdl_valid [NSETS][NWAYS];
   logic                          mdl_dirty [NSETS][NWAYS];
   int unsigned                   mdl_order [NSETS][NWAYS];

   outcome_type pending_outcomes[$];
   int errors = 0;
   int responses = 0;
   int cycles = 0;
   int fills_seen = 0, dirty_evicts = 0, hits_seen = 0;
   bit quiet = 1'b0;            // last stretch: no idling either side
   bit hold_rsp = 1'b0;         // long receiver hold-off request
   bit done_driving = 1'b0;

   task automatic report(input string what, input logic [sacl_pkg::TAG_BITS-1:0] got,
                         input logic [sacl_pkg::TAG_BITS-1:0] exp);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
      errors++;
   endtask

   function automatic void tags_reset();
      for (int s = 0; s < NSETS; s++)
         for (int w = 0; w < NWAYS; w++) begin
            mdl_tag[s][w] = '0;
            mdl_valid[s][w] = 1'b0;
            mdl_dirty[s][w] = 1'b0;
            mdl_order[s][w] = w;
         end
   endfunction

   // move recency position p to the front of set s
   function automatic void make_recent(int s, int p);
      int unsigned w;
      w = mdl_order[s][p];
      for (int i = p; i > 0; i--) mdl_order[s][i] = mdl_order[s][i-1];
      mdl_order[s][0] = w;
   endfunction

   function automatic outcome_type cache_access(row_type r);
      outcome_type o;
      int s, p;
      int unsigned w;
      o = '0;
      s = r.set_index;
      if (r.cmd == sacl_pkg::CMD_READ || r.cmd == sacl_pkg::CMD_WRITE) begin
         for (p = 0; p < NWAYS; p++) begin
            w = mdl_order[s][p];
            if (mdl_valid[s][w] && mdl_tag[s][w] == r.tag) begin
               o.hit = 1'b1;
               if (r.cmd == sacl_pkg::CMD_WRITE) mdl_dirty[s][w] = 1'b1;
               make_recent(s, p);
               break;
            end
         end
      end else if (r.cmd == sacl_pkg::CMD_FILL) begin
         p = 0;
         while (p + 1 < NWAYS && mdl_valid[s][mdl_order[s][p]]) p++;
         w = mdl_order[s][p];
         if (!mdl_valid[s][w]) o.kind = sacl_pkg::KIND_EMPTY;
         else if (!mdl_dirty[s][w]) o.kind = sacl_pkg::KIND_CLEAN;
         else begin
            o.kind = sacl_pkg::KIND_DIRTY;
            o.etag = mdl_tag[s][w];
         end
         mdl_tag[s][w] = r.tag;
         mdl_valid[s][w] = 1'b1;
         mdl_dirty[s][w] = r.fdirty;
         make_recent(s, p);
      end
      return o;
   endfunction

   function automatic row_type mk(logic [sacl_pkg::CMD_BITS-1:0] c, int s,
                                  logic [sacl_pkg::TAG_BITS-1:0] t,
                                  logic d, logic chk = 0, logic h = 0,
                                  logic [sacl_pkg::KIND_BITS-1:0] k = sacl_pkg::KIND_EMPTY,
                                  logic [sacl_pkg::TAG_BITS-1:0] e = '0);
      row_type r;
      r.cmd = c; r.set_index = sacl_pkg::SET_BITS'(s); r.tag = t; r.fdirty = d;
      r.chk = chk; r.want.hit = h; r.want.kind = k; r.want.etag = e;
      return r;
   endfunction

   // Directed table: extremes of set and tag, every command, the LRU victim,
   // dirty eviction, a fill that clears dirty, duplicate tags and the spare
   // command.
   row_type directed[$];
   initial begin
      directed = '{
         mk(sacl_pkg::CMD_READ,  0,  20'h00000, 0, 1, 0, sacl_pkg::KIND_EMPTY), // after reset
         mk(sacl_pkg::CMD_FILL,  63, 20'hFFFFF, 1, 1, 0, sacl_pkg::KIND_EMPTY),
         mk(sacl_pkg::CMD_READ,  63, 20'hFFFFF, 0, 1, 1, sacl_pkg::KIND_EMPTY),
         mk(sacl_pkg::CMD_FILL,  63, 20'h00000, 0, 1, 0, sacl_pkg::KIND_EMPTY),
         mk(sacl_pkg::CMD_FILL,  63, 20'h12345, 0, 1, 0, sacl_pkg::KIND_EMPTY),
         mk(sacl_pkg::CMD_FILL,  63, 20'hABCDE, 0, 1, 0, sacl_pkg::KIND_EMPTY),
         // set full: least recent is the dirty FFFFF line
         mk(sacl_pkg::CMD_FILL,  63, 20'h55555, 0, 1, 0, sacl_pkg::KIND_DIRTY, 20'hFFFFF),
         mk(sacl_pkg::CMD_FILL,  63, 20'hAAAAA, 1, 1, 0, sacl_pkg::KIND_CLEAN),
         mk(sacl_pkg::CMD_WRITE, 63, 20'h12345, 0),
         mk(sacl_pkg::CMD_READ,  63, 20'hABCDE, 0),
         mk(sacl_pkg::CMD_FILL,  63, 20'h00001, 0),
         mk(sacl_pkg::CMD_FILL,  63, 20'h00002, 0),
         mk(sacl_pkg::CMD_FILL,  63, 20'h00003, 0),
         mk(sacl_pkg::CMD_FILL,  63, 20'h00004, 0),
         mk(sacl_pkg::CMD_NOP,   63, 20'h00004, 1, 1, 0, sacl_pkg::KIND_EMPTY), // spare command
         mk(sacl_pkg::CMD_FILL,  0,  20'h00007, 0),
         mk(sacl_pkg::CMD_FILL,  0,  20'h00007, 1),                 // duplicate tag
         mk(sacl_pkg::CMD_WRITE, 0,  20'h00007, 0),
         mk(sacl_pkg::CMD_FILL,  0,  20'h00008, 0),
         mk(sacl_pkg::CMD_FILL,  0,  20'h00009, 0),
         mk(sacl_pkg::CMD_FILL,  0,  20'h0000A, 0),
         mk(sacl_pkg::CMD_FILL,  0,  20'h0000B, 0),
         mk(sacl_pkg::CMD_READ,  0,  20'h00007, 0),
         mk(sacl_pkg::CMD_WRITE, 1,  20'h00000, 0)
      };
   end

   function automatic row_type random_row();
      row_type r;
      int sel;
      sel = $urandom_range(0, 99);
      r = '0;
      // few hot sets and a small tag pool keep hits and evictions frequent
      r.set_index = (sel < 85) ? sacl_pkg::SET_BITS'($urandom_range(0, 3))
                               : sacl_pkg::SET_BITS'($urandom_range(0, NSETS-1));
      r.tag = (sel < 90) ? 20'($urandom_range(0, 9)) : 20'($urandom);
      r.fdirty = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      r.cmd = sel < 35 ? sacl_pkg::CMD_READ : sel < 60 ? sacl_pkg::CMD_WRITE :
              sel < 97 ? sacl_pkg::CMD_FILL : sacl_pkg::CMD_NOP;
      return r;
   endfunction

   // sender: drive a row and hold it until accepted
   task automatic send(row_type r);
      outcome_type o;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_set_index <= r.set_index;
      req_tag <= r.tag;
      req_fill_dirty <= r.fdirty;
      do @(posedge clock); while (req_stall);
      o = cache_access(r);
      if (r.chk && o != r.want) begin
         $display("%0t table row disagrees with model for cmd %0d", $realtime, r.cmd);
         errors++;
      end
      if (o.kind == sacl_pkg::KIND_DIRTY) dirty_evicts++;
      if (r.cmd == sacl_pkg::CMD_FILL) fills_seen++;
      pending_outcomes.push_back(r.chk ? r.want : o);
   endtask

   initial begin
      tags_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send(directed[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 200) hold_rsp = 1'b1;
         if (n == 500) begin
            req_valid <= 1'b0;
            wait (pending_outcomes.size() == 0);
         end
         if (n == N_RANDOM - 150) quiet = 1'b1;
         send(random_row());
      end
      req_valid <= 1'b0;
      done_driving = 1'b1;
   end

   // receiver: random stall bursts, plus one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t response with nothing outstanding", $realtime);
            errors++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_hit) hits_seen++;
            if (rsp_hit !== e.hit)
               report("hit", sacl_pkg::TAG_BITS'(rsp_hit), sacl_pkg::TAG_BITS'(e.hit));
            if (rsp_victim_kind !== e.kind)
               report("victim_kind", sacl_pkg::TAG_BITS'(rsp_victim_kind),
                      sacl_pkg::TAG_BITS'(e.kind));
            if (rsp_evicted_tag !== e.etag) report("evicted_tag", rsp_evicted_tag, e.etag);
         end
      end
   end

   // end of run and watchdog
   initial begin
      fork
         begin
            wait (done_driving && pending_outcomes.size() == 0);
            repeat (20) @(posedge clock);
         end
         begin
            while (cycles < CYCLE_LIMIT) begin
               @(posedge clock);
               cycles++;
            end
            $display("timeout with %0d responses outstanding", pending_outcomes.size());
            errors++;
         end
      join_any
      $display("%0d responses: %0d hits, %0d fills, %0d dirty evictions",
               responses, hits_seen, fills_seen, dirty_evicts);
      $display("covered LRU victims, dirty write-back, long response hold-off");
      if (errors == 0 && pending_outcomes.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
`default_nettype wire

// File: set_assoc_cache_lru_writeback_top.f
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/sacl_ram.sv
rtl/set_assoc_cache_lru_writeback_top.sv
test/tb_top.sv
